/* hdl/isotp_tx_segmenter_macros.svh */
// assertion macros used by the isotp_ctrl module of the segmenter
// expects clk and rst_n in the scope of each use
`ifndef ISOTP_TX_SEGMENTER_MACROS_SVH
`define ISOTP_TX_SEGMENTER_MACROS_SVH

// same-cycle implication, disabled during reset
`define ISOTP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("isotp check failed");

// next-cycle implication, disabled during reset
`define ISOTP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("isotp check failed");

`endif

/* hdl/isotp_pkg.sv */
// types and constants of the iso-tp transmit segmenter
// no dependencies
`timescale 1ns / 1ps

package isotp_pkg;

    localparam int BUFFER_BYTES_DEF = 1024;
    localparam int LEN_W            = 12;
    localparam int FRAME_BYTES      = 8;
    localparam int SLOT_W           = 3;

    localparam logic [7:0]        PAD_RESET   = 8'hAA;
    localparam logic [7:0]        BLOCK_RESET = 8'h20;
    localparam logic [LEN_W-1:0]  SINGLE_MAX  = 12'd7;
    localparam logic [SLOT_W-1:0] LAST_SLOT   = 3'd7;

    // frame type nibbles of the control byte
    localparam logic [3:0] NIB_SINGLE = 4'h0;
    localparam logic [3:0] NIB_FIRST  = 4'h1;
    localparam logic [3:0] NIB_CONSEC = 4'h2;

    typedef enum logic [1:0] {
        ACT_WRITE  = 2'd0,
        ACT_SUBMIT = 2'd1,
        ACT_TICK   = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_SINGLE = 3'd1,
        PH_FIRST  = 3'd2,
        PH_WAIT   = 3'd3,
        PH_CONSEC = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        REQ_NONE     = 2'd0,
        REQ_ACCEPTED = 2'd1,
        REQ_REJECTED = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_LAST,
        ST_EMIT
    } state_t;

    typedef enum logic [0:0] {
        REG_PADDING    = 1'b0,
        REG_BLOCK_SIZE = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]       action;
        logic [7:0]       payload_byte;
        logic [LEN_W-1:0] sdu_length;
    } cmd_t;

    typedef struct packed {
        logic [7:0] padding_byte;
        logic [7:0] block_size;
    } cfg_t;

    typedef struct packed {
        logic                        frame_valid;
        logic [FRAME_BYTES-1:0][7:0] bytes;
        req_t                        request_result;
        phase_t                      phase;
    } result_t;

endpackage

/* hdl/isotp_tx_segmenter.sv */
// top level of the iso-tp transmit segmenter: config registers, result word register
// depends on isotp_pkg, isotp_ctrl, isotp_ram
`timescale 1ns / 1ps

// channel   | handshake              | word
// command   | start / busy           | action, payload_byte, sdu_length
// result    | done (one-cycle pulse) | frame_valid, frame_byte_0..7, request_result,
//           |                        | channel_phase
// config    | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// write, submit, and ticks that send no frame leave busy low; done rises the next cycle
// a tick that sends a frame holds busy through the fill, last and emit states and done
// rises as busy falls: the byte slots are filled one a cycle
// through the single read port of the payload store
// rst_n clears channel state and config; the payload store keeps its contents
// results cannot be stalled; cfg_ready is always high

module isotp_tx_segmenter
    import isotp_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       action,
    input  logic [7:0]       payload_byte,
    input  logic [LEN_W-1:0] sdu_length,
    output logic             done,
    output logic             frame_valid,
    output logic [7:0]       frame_byte_0,
    output logic [7:0]       frame_byte_1,
    output logic [7:0]       frame_byte_2,
    output logic [7:0]       frame_byte_3,
    output logic [7:0]       frame_byte_4,
    output logic [7:0]       frame_byte_5,
    output logic [7:0]       frame_byte_6,
    output logic [7:0]       frame_byte_7,
    output logic [1:0]       request_result,
    output logic [2:0]       channel_phase,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [0:0]       cfg_index,
    input  logic [7:0]       cfg_data
);

    localparam int AW = $clog2(BUFFER_BYTES);

    cfg_t          cfg_reg;
    cmd_t          cmd;
    result_t       res;
    result_t       res_reg;
    logic          ctrl_done;
    logic          done_reg;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    assign cmd.action       = action;
    assign cmd.payload_byte = payload_byte;
    assign cmd.sdu_length   = sdu_length;
    assign cfg_ready        = 1'b1;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.padding_byte <= PAD_RESET;
            cfg_reg.block_size   <= BLOCK_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PADDING:    cfg_reg.padding_byte <= cfg_data;
                REG_BLOCK_SIZE: cfg_reg.block_size   <= cfg_data;
            endcase
        end
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl_done;
        end
    end

    // result word register
    always_ff @(posedge clk)
    begin
        if (ctrl_done)
        begin
            res_reg <= res;
        end
    end

    isotp_ctrl #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .cmd      (cmd),
        .cfg      (cfg_reg),
        .busy     (busy),
        .done     (ctrl_done),
        .res      (res),
        .ram_we   (ram_we),
        .ram_waddr(ram_waddr),
        .ram_wdata(ram_wdata),
        .ram_raddr(ram_raddr),
        .ram_rdata(ram_rdata)
    );

    isotp_ram #(
        .DEPTH(BUFFER_BYTES)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign done           = done_reg;
    assign frame_valid    = res_reg.frame_valid;
    assign frame_byte_0   = res_reg.bytes[0];
    assign frame_byte_1   = res_reg.bytes[1];
    assign frame_byte_2   = res_reg.bytes[2];
    assign frame_byte_3   = res_reg.bytes[3];
    assign frame_byte_4   = res_reg.bytes[4];
    assign frame_byte_5   = res_reg.bytes[5];
    assign frame_byte_6   = res_reg.bytes[6];
    assign frame_byte_7   = res_reg.bytes[7];
    assign request_result = res_reg.request_result;
    assign channel_phase  = res_reg.phase;

endmodule

/* hdl/isotp_ram.sv */
// payload byte store, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module isotp_ram #(
    parameter int  DEPTH = 1024,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/isotp_ctrl.sv */
// command sequencer: channel state, frame assembly one byte slot per cycle
// depends on isotp_pkg, isotp_tx_segmenter_macros.svh
`timescale 1ns / 1ps
`include "isotp_tx_segmenter_macros.svh"

module isotp_ctrl
    import isotp_pkg::*;
#(
    parameter int  BUFFER_BYTES = BUFFER_BYTES_DEF,
    localparam int AW           = $clog2(BUFFER_BYTES),
    localparam int PTR_W        = $clog2(BUFFER_BYTES + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  cmd_t          cmd,
    input  cfg_t          cfg,
    output logic          busy,
    output logic          done,
    output result_t       res,
    output logic          ram_we,
    output logic [AW-1:0] ram_waddr,
    output logic [7:0]    ram_wdata,
    output logic [AW-1:0] ram_raddr,
    input  logic [7:0]    ram_rdata
);

    localparam logic [PTR_W-1:0] BUF_P   = PTR_W'(BUFFER_BYTES);
    localparam logic [LEN_W-1:0] BUF_LEN = LEN_W'(BUFFER_BYTES);

    state_t                      state_reg, state_next;
    phase_t                      phase_reg, phase_next;
    logic [PTR_W-1:0]            wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]            total_reg, total_next;
    logic [PTR_W-1:0]            sent_reg, sent_next;
    logic [3:0]                  seq_reg, seq_next;
    logic [7:0]                  blk_reg, blk_next;
    logic [SLOT_W-1:0]           slot_reg, slot_next;
    logic                        pend_reg, pend_next;
    logic [SLOT_W-1:0]           pend_slot_reg, pend_slot_next;
    logic [FRAME_BYTES-1:0][7:0] frame_reg, frame_next;

    logic             more_bytes;
    logic [LEN_W-1:0] total12;
    logic [3:0]       seq_inc;
    logic [7:0]       blk_inc;
    logic             res_valid;
    req_t             res_req;

    // shared compare: bytes still to send
    assign more_bytes = sent_reg < total_reg;
    assign total12    = LEN_W'(total_reg);
    assign seq_inc    = seq_reg + 4'd1;
    assign blk_inc    = blk_reg + 8'd1;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            phase_reg  <= PH_IDLE;
            wr_ptr_reg <= '0;
            total_reg  <= '0;
            sent_reg   <= '0;
            seq_reg    <= '0;
            blk_reg    <= '0;
            slot_reg   <= '0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            wr_ptr_reg <= wr_ptr_next;
            total_reg  <= total_next;
            sent_reg   <= sent_next;
            seq_reg    <= seq_next;
            blk_reg    <= blk_next;
            slot_reg   <= slot_next;
            pend_reg   <= pend_next;
        end
    end

    // frame under assembly
    always_ff @(posedge clk)
    begin
        frame_reg     <= frame_next;
        pend_slot_reg <= pend_slot_next;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        wr_ptr_next    = wr_ptr_reg;
        total_next     = total_reg;
        sent_next      = sent_reg;
        seq_next       = seq_reg;
        blk_next       = blk_reg;
        slot_next      = slot_reg;
        pend_next      = pend_reg;
        pend_slot_next = pend_slot_reg;
        frame_next     = frame_reg;
        ram_we         = 1'b0;
        ram_waddr      = wr_ptr_reg[AW-1:0];
        ram_wdata      = cmd.payload_byte;
        ram_raddr      = sent_reg[AW-1:0];
        done           = 1'b0;
        res_valid      = 1'b0;
        res_req        = REQ_NONE;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    done = 1'b1;
                    case (cmd.action)
                        ACT_WRITE:
                        begin
                            if (phase_reg == PH_IDLE && wr_ptr_reg < BUF_P)
                            begin
                                ram_we      = 1'b1;
                                wr_ptr_next = wr_ptr_reg + 1'b1;
                            end
                        end
                        ACT_SUBMIT:
                        begin
                            if (phase_reg == PH_IDLE)
                            begin
                                sent_next   = '0;
                                wr_ptr_next = '0;
                                total_next  = (cmd.sdu_length < BUF_LEN) ?
                                              PTR_W'(cmd.sdu_length) : BUF_P;
                                phase_next  = (cmd.sdu_length <= SINGLE_MAX) ?
                                              PH_SINGLE : PH_FIRST;
                                res_req     = REQ_ACCEPTED;
                            end
                            else
                            begin
                                res_req = REQ_REJECTED;
                            end
                        end
                        ACT_TICK:
                        begin
                            case (phase_reg)
                                PH_SINGLE:
                                begin
                                    done          = 1'b0;
                                    frame_next[0] = {NIB_SINGLE, total_reg[3:0]};
                                    slot_next     = SLOT_W'(1);
                                    pend_next     = 1'b0;
                                    state_next    = ST_FILL;
                                end
                                PH_FIRST:
                                begin
                                    done          = 1'b0;
                                    frame_next[0] = {NIB_FIRST, total12[11:8]};
                                    frame_next[1] = total12[7:0];
                                    slot_next     = SLOT_W'(2);
                                    pend_next     = 1'b0;
                                    state_next    = ST_FILL;
                                end
                                PH_WAIT:
                                begin
                                    blk_next   = '0;
                                    phase_next = PH_CONSEC;
                                end
                                PH_CONSEC:
                                begin
                                    done          = 1'b0;
                                    seq_next      = seq_inc;
                                    frame_next[0] = {NIB_CONSEC, seq_inc};
                                    slot_next     = SLOT_W'(1);
                                    pend_next     = 1'b0;
                                    state_next    = ST_FILL;
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // one slot per cycle: read the store or pad
            ST_FILL:
            begin
                if (pend_reg)
                begin
                    frame_next[pend_slot_reg] = ram_rdata;
                end
                if (more_bytes)
                begin
                    sent_next      = sent_reg + 1'b1;
                    pend_next      = 1'b1;
                    pend_slot_next = slot_reg;
                end
                else
                begin
                    frame_next[slot_reg] = cfg.padding_byte;
                    pend_next            = 1'b0;
                end
                if (slot_reg == LAST_SLOT)
                begin
                    state_next = ST_LAST;
                end
                else
                begin
                    slot_next = slot_reg + 1'b1;
                end
            end

            // land the final read
            ST_LAST:
            begin
                if (pend_reg)
                begin
                    frame_next[pend_slot_reg] = ram_rdata;
                end
                pend_next  = 1'b0;
                state_next = ST_EMIT;
            end

            // hand out the frame and move the channel on
            ST_EMIT:
            begin
                done       = 1'b1;
                res_valid  = 1'b1;
                state_next = ST_IDLE;
                case (phase_reg)
                    PH_FIRST:
                    begin
                        seq_next   = '0;
                        phase_next = PH_WAIT;
                    end
                    PH_CONSEC:
                    begin
                        if (more_bytes)
                        begin
                            blk_next   = blk_inc;
                            phase_next = (blk_inc < cfg.block_size) ? PH_CONSEC : PH_WAIT;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        endcase
    end

    assign busy               = state_reg != ST_IDLE;
    assign res.frame_valid    = res_valid;
    assign res.bytes          = res_valid ? frame_reg : '0;
    assign res.request_result = res_req;
    assign res.phase          = phase_next;

    // checks
    `ISOTP_ASSERT_NOW(a_sent_in_range, state_reg != ST_IDLE, sent_reg <= total_reg)
    `ISOTP_ASSERT_NOW(a_fill_phase, state_reg == ST_FILL,
        phase_reg == PH_SINGLE || phase_reg == PH_FIRST || phase_reg == PH_CONSEC)
    `ISOTP_ASSERT_NOW(a_quick_cmd_done,
        state_reg == ST_IDLE && start && cmd.action != ACT_TICK, done && !res.frame_valid)
    `ISOTP_ASSERT_NEXT(a_wait_leaves,
        state_reg == ST_IDLE && start && cmd.action == ACT_TICK && phase_reg == PH_WAIT,
        phase_reg == PH_CONSEC && blk_reg == 8'd0)
    `ISOTP_ASSERT_NEXT(a_emit_returns, state_reg == ST_EMIT, state_reg == ST_IDLE)

endmodule

/* tb/testbench.sv */
// self-checking testbench of the iso-tp transmit segmenter: directed and random command words
// depends on isotp_pkg and the isotp_tx_segmenter rtl
`timescale 1ns / 1ps

module testbench;
    import isotp_pkg::*;

    localparam int         BUF_BYTES  = BUFFER_BYTES_DEF;
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int         ITEM_GOAL  = 1550;

    // channel state copy that works out the result word of every command
    class frame_scoreboard;
        logic [7:0] pad_byte;
        logic [7:0] blk_size;
        logic [7:0] store [BUF_BYTES];
        int         wr_ptr;
        int         total;
        int         sent;
        logic [3:0] seq;
        logic [7:0] blk_cnt;
        phase_t     phase;
        result_t    expected_frames[$];
        int         faults;

        function new();
            pad_byte = PAD_RESET;
            blk_size = BLOCK_RESET;
            wr_ptr   = 0;
            total    = 0;
            sent     = 0;
            seq      = '0;
            blk_cnt  = '0;
            phase    = PH_IDLE;
            faults   = 0;
        endfunction

        function logic [7:0] pull_byte();
            logic [7:0] v;
            v    = store[sent];
            sent = sent + 1;
            return v;
        endfunction

        function void flag(string what, logic [11:0] want, logic [11:0] got);
            faults++;
            if (faults <= 10)
                $display("mismatch on %s: expected %0h, actual %0h", what, want, got);
        endfunction

        // returns 0 for an unused action or a write or tick that left the channel unchanged, else 1
        function bit take_command(logic [1:0] act, logic [7:0] pbyte, logic [LEN_W-1:0] len);
            result_t r;
            bit      moved;
            r     = '0;
            moved = 1'b1;
            case (act)
                ACT_WRITE:
                begin
                    if (phase == PH_IDLE && wr_ptr < BUF_BYTES)
                    begin
                        store[wr_ptr] = pbyte;
                        wr_ptr        = wr_ptr + 1;
                    end
                    else
                        moved = 1'b0;
                end
                ACT_SUBMIT:
                begin
                    if (phase == PH_IDLE)
                    begin
                        sent             = 0;
                        wr_ptr           = 0;
                        total            = (len < BUF_BYTES) ? int'(len) : BUF_BYTES;
                        phase            = (len <= SINGLE_MAX) ? PH_SINGLE : PH_FIRST;
                        r.request_result = REQ_ACCEPTED;
                    end
                    else
                        r.request_result = REQ_REJECTED;
                end
                ACT_TICK:
                begin
                    case (phase)
                        PH_SINGLE:
                        begin
                            r.frame_valid = 1'b1;
                            r.bytes[0]    = {NIB_SINGLE, 4'(total)};
                            for (int i = 1; i < FRAME_BYTES; i++)
                            begin
                                if (i <= total)
                                    r.bytes[i] = pull_byte();
                                else
                                    r.bytes[i] = pad_byte;
                            end
                            phase = PH_IDLE;
                        end
                        PH_FIRST:
                        begin
                            r.frame_valid = 1'b1;
                            r.bytes[0]    = {NIB_FIRST, 4'(total >> 8)};
                            r.bytes[1]    = 8'(total);
                            for (int i = 2; i < FRAME_BYTES; i++)
                                r.bytes[i] = pull_byte();
                            seq   = '0;
                            phase = PH_WAIT;
                        end
                        // silent tick standing in for flow control
                        PH_WAIT:
                        begin
                            blk_cnt = '0;
                            phase   = PH_CONSEC;
                        end
                        PH_CONSEC:
                        begin
                            seq           = seq + 4'd1;
                            r.frame_valid = 1'b1;
                            r.bytes[0]    = {NIB_CONSEC, seq};
                            for (int i = 1; i < FRAME_BYTES; i++)
                            begin
                                if (sent < total)
                                    r.bytes[i] = pull_byte();
                                else
                                    r.bytes[i] = pad_byte;
                            end
                            if (sent < total)
                            begin
                                blk_cnt = blk_cnt + 8'd1;
                                phase   = (blk_cnt < blk_size) ? PH_CONSEC : PH_WAIT;
                            end
                            else
                                phase = PH_IDLE;
                        end
                        default:
                            moved = 1'b0;
                    endcase
                end
                default:
                    moved = 1'b0;
            endcase
            r.phase = phase;
            expected_frames.push_back(r);
            return moved;
        endfunction

        function void match_frame(result_t seen);
            result_t want;
            if (expected_frames.size() == 0)
            begin
                flag("unexpected result word", 12'd0, 12'd0);
                return;
            end
            want = expected_frames.pop_front();
            if (seen.frame_valid !== want.frame_valid)
                flag("frame_valid", want.frame_valid, seen.frame_valid);
            for (int i = 0; i < FRAME_BYTES; i++)
            begin
                if (seen.bytes[i] !== want.bytes[i])
                    flag($sformatf("frame_byte_%0d", i), want.bytes[i], seen.bytes[i]);
            end
            if (seen.request_result !== want.request_result)
                flag("request_result", want.request_result, seen.request_result);
            if (seen.phase !== want.phase)
                flag("channel_phase", want.phase, seen.phase);
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction

        // words still expected at the end are failures
        function void flush_missing();
            result_t want;
            while (expected_frames.size() != 0)
            begin
                want = expected_frames.pop_front();
                flag("missing result word", want.phase, 12'd0);
            end
        endfunction
    endclass

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             start        = 1'b0;
    logic             busy;
    logic [1:0]       action       = ACT_WRITE;
    logic [7:0]       payload_byte = 8'd0;
    logic [LEN_W-1:0] sdu_length   = '0;
    logic             done;
    logic             frame_valid;
    logic [7:0]       frame_byte_0;
    logic [7:0]       frame_byte_1;
    logic [7:0]       frame_byte_2;
    logic [7:0]       frame_byte_3;
    logic [7:0]       frame_byte_4;
    logic [7:0]       frame_byte_5;
    logic [7:0]       frame_byte_6;
    logic [7:0]       frame_byte_7;
    logic [1:0]       request_result;
    logic [2:0]       channel_phase;
    logic             cfg_valid    = 1'b0;
    logic             cfg_ready;
    logic [0:0]       cfg_index    = REG_PADDING;
    logic [7:0]       cfg_data     = 8'd0;

    frame_scoreboard sb = new();
    int              issued = 0;
    bit              burst  = 1'b0;

    isotp_tx_segmenter dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .action         (action),
        .payload_byte   (payload_byte),
        .sdu_length     (sdu_length),
        .done           (done),
        .frame_valid    (frame_valid),
        .frame_byte_0   (frame_byte_0),
        .frame_byte_1   (frame_byte_1),
        .frame_byte_2   (frame_byte_2),
        .frame_byte_3   (frame_byte_3),
        .frame_byte_4   (frame_byte_4),
        .frame_byte_5   (frame_byte_5),
        .frame_byte_6   (frame_byte_6),
        .frame_byte_7   (frame_byte_7),
        .request_result (request_result),
        .channel_phase  (channel_phase),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #4 clk = ~clk;

    // result word monitor, sampled at the edge that ends the done cycle
    always @(posedge clk)
    begin : watch_results
        result_t seen;
        if (rst_n && done)
        begin
            seen.frame_valid    = frame_valid;
            seen.bytes[0]       = frame_byte_0;
            seen.bytes[1]       = frame_byte_1;
            seen.bytes[2]       = frame_byte_2;
            seen.bytes[3]       = frame_byte_3;
            seen.bytes[4]       = frame_byte_4;
            seen.bytes[5]       = frame_byte_5;
            seen.bytes[6]       = frame_byte_6;
            seen.bytes[7]       = frame_byte_7;
            seen.request_result = req_t'(request_result);
            seen.phase          = phase_t'(channel_phase);
            sb.match_frame(seen);
        end
    end

    // one command word, after a random gap unless in a burst
    task automatic send(logic [1:0] act, logic [7:0] pbyte, logic [LEN_W-1:0] len);
        int gap;
        int roll;
        gap  = 0;
        roll = $urandom_range(0, 99);
        if (!burst)
        begin
            if (roll >= 90)
                gap = $urandom_range(8, 40);
            else if (roll >= 50)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        action       <= act;
        payload_byte <= pbyte;
        sdu_length   <= len;
        do @(posedge clk); while (busy);
        if (sb.take_command(act, pbyte, len))
            issued++;
    endtask

    // stop issuing and wait for every expected word
    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    // both registers, back to back, with the channel quiet
    task automatic set_config(logic [7:0] pad, logic [7:0] bsize);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= REG_PADDING;
        cfg_data  <= pad;
        do @(posedge clk); while (!cfg_ready);
        sb.pad_byte = pad;
        cfg_index <= REG_BLOCK_SIZE;
        cfg_data  <= bsize;
        do @(posedge clk); while (!cfg_ready);
        sb.blk_size = bsize;
        cfg_valid <= 1'b0;
    endtask

    // payload writes, a submit, then ticks until idle with some noise mixed in
    task automatic run_message(int n_writes, logic [LEN_W-1:0] len);
        logic [1:0] noise;
        for (int i = 0; i < n_writes; i++)
            send(ACT_WRITE, 8'($urandom), LEN_W'($urandom));
        send(ACT_SUBMIT, 8'($urandom), len);
        while (sb.phase != PH_IDLE)
        begin
            if ($urandom_range(0, 99) < 8)
            begin
                case ($urandom_range(0, 2))
                    0:       noise = ACT_WRITE;
                    1:       noise = ACT_SUBMIT;
                    default: noise = ACT_UNUSED;
                endcase
                send(noise, 8'($urandom), LEN_W'($urandom));
            end
            else
                send(ACT_TICK, 8'($urandom), LEN_W'($urandom));
        end
    endtask

    initial
    begin : stimulus
        logic [7:0]       pad;
        logic [7:0]       bsize;
        logic [LEN_W-1:0] len;
        int               roll;
        int               n_writes;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // idle tick, unused action, empty single frame, busy submit and write
        send(ACT_TICK, 8'h00, 12'h000);
        send(ACT_UNUSED, 8'hFF, 12'hFFF);
        send(ACT_SUBMIT, 8'h00, 12'd0);
        send(ACT_SUBMIT, 8'h00, 12'd5);
        send(ACT_WRITE, 8'h5A, 12'd0);
        send(ACT_TICK, 8'h00, 12'd0);

        // edge byte values, then a full single frame
        send(ACT_WRITE, 8'h00, 12'd0);
        send(ACT_WRITE, 8'hFF, 12'd0);
        send(ACT_WRITE, 8'h55, 12'd0);
        send(ACT_WRITE, 8'hAA, 12'd0);
        send(ACT_WRITE, 8'h01, 12'd0);
        send(ACT_WRITE, 8'h80, 12'd0);
        send(ACT_WRITE, 8'h7F, 12'd0);
        send(ACT_WRITE, 8'hFE, 12'd0);
        send(ACT_SUBMIT, 8'h00, 12'd7);
        send(ACT_TICK, 8'h00, 12'd0);

        // shortest first frame, flow-control wait, padded consecutive frame
        send(ACT_SUBMIT, 8'h00, 12'd8);
        send(ACT_TICK, 8'h00, 12'd0);
        send(ACT_TICK, 8'h00, 12'd0);
        send(ACT_SUBMIT, 8'h00, 12'd3);
        send(ACT_TICK, 8'h00, 12'd0);
        send(ACT_TICK, 8'h00, 12'd0);

        // whole store plus writes past its end, longest length capped
        set_config(8'h00, 8'hFF);
        run_message(BUF_BYTES + 6, 12'hFFF);

        // one frame per block, then the zero block size
        set_config(8'hFF, 8'h01);
        run_message(0, 12'd40);
        set_config(8'($urandom), 8'h00);
        run_message(3, 12'd30);

        // random messages, mostly short
        while (issued < ITEM_GOAL)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       pad = 8'h00;
                    1:       pad = 8'hFF;
                    default: pad = 8'($urandom);
                endcase
                case ($urandom_range(0, 5))
                    0:       bsize = 8'h00;
                    1:       bsize = 8'h01;
                    2:       bsize = 8'h02;
                    3:       bsize = 8'hFF;
                    default: bsize = 8'($urandom_range(1, 16));
                endcase
                set_config(pad, bsize);
            end
            burst = ($urandom_range(0, 3) == 0);
            roll  = $urandom_range(0, 99);
            if (roll < 80)
                len = LEN_W'($urandom_range(0, 40));
            else if (roll < 96)
                len = LEN_W'($urandom_range(41, 200));
            else
                len = LEN_W'($urandom_range(0, 4095));
            n_writes = $urandom_range(0, (len > 40) ? 40 : int'(len) + 3);
            // stray words between messages
            if ($urandom_range(0, 9) == 0)
                send(ACT_TICK, 8'($urandom), LEN_W'($urandom));
            if ($urandom_range(0, 19) == 0)
                send(ACT_UNUSED, 8'($urandom), LEN_W'($urandom));
            run_message(n_writes, len);
        end

        // wind down and report
        burst = 1'b0;
        drain();
        repeat (20) @(posedge clk);
        sb.flush_missing();
        if (sb.faults == 0)
            $display("[isotp_tx_segmenter] OK");
        else
            $display("[isotp_tx_segmenter] ERROR");
        $finish;
    end

    // run limit
    initial
    begin
        #10_000_000;
        $display("[isotp_tx_segmenter] ERROR");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hdl
hdl/isotp_pkg.sv
hdl/isotp_ram.sv
hdl/isotp_ctrl.sv
hdl/isotp_tx_segmenter.sv
tb/testbench.sv
